@@ rtl/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, character codes and helper functions of the counter frame
// deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // byte window of the frame tail, newest byte at index 0
    localparam int WINDOW_BYTES = 13;
    // the newest window byte is the live input and is not stored, so one less is kept
    localparam int WinDepth     = WINDOW_BYTES - 1;

    localparam int CfgIdxW = 8;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] REG_MIN_LEN  = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_MAX_SPAN = 8'd1;

    localparam logic [7:0] MIN_LEN_RESET  = 8'd30;
    localparam logic [7:0] MAX_SPAN_RESET = 8'd200;

    // character codes
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_CHECKSUM  = 3'd2;
    localparam logic [2:0] ST_LONG      = 3'd3;
    localparam logic [2:0] ST_BAD_DOOR  = 3'd4;
    localparam logic [2:0] ST_BAD_UP    = 3'd5;
    localparam logic [2:0] ST_BAD_DOWN  = 3'd6;

    typedef struct packed {
        logic [7:0] min_len;
        logic [7:0] max_span;
    } t_cfg;

    typedef struct packed {
        logic [2:0] frame_status;
        logic [3:0] door_number;
        logic [9:0] boarding_count;
        logic [9:0] alighting_count;
        logic [7:0] frame_length;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // three ascii digits, hundreds first
    function automatic logic [9:0] dec3(input logic [7:0] h, input logic [7:0] t,
                                        input logic [7:0] o);
        return 10'(h[3:0]) * 10'd100 + 10'(t[3:0]) * 10'd10 + 10'(o[3:0]);
    endfunction

endpackage

@@ rtl/cfd_ifs.sv @@
// ----------------------------------------------------------------------------
// cfd channel interfaces
// Byte input, frame result and configuration write channels, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface cfd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] frame_status;
    logic [3:0] door_number;
    logic [9:0] boarding_count;
    logic [9:0] alighting_count;
    logic [7:0] frame_length;

    modport source (output valid, output frame_status, output door_number,
                    output boarding_count, output alighting_count,
                    output frame_length, input ready);
    modport sink   (input valid, input frame_status, input door_number,
                    input boarding_count, input alighting_count,
                    input frame_length, output ready);
endinterface

interface cfd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [cfd_pkg::CfgIdxW-1:0] index;
    logic [7:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cfd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cfd_cfg_regs
// Configuration registers: minimum frame length and maximum header-to-percent
// span, written through the configuration channel.
// ----------------------------------------------------------------------------
module cfd_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfd_cfg_if.sink           i_cfg,
    output cfd_pkg::t_cfg     o_cfg
);

    cfd_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_len  <= cfd_pkg::MIN_LEN_RESET;
            r_cfg.max_span <= cfd_pkg::MAX_SPAN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cfd_pkg::REG_MIN_LEN:  r_cfg.min_len  <= i_cfg.data;
                cfd_pkg::REG_MAX_SPAN: r_cfg.max_span <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/cfd_frame_core.sv @@
// ----------------------------------------------------------------------------
// cfd_frame_core
// Header hunt, tail window, lagged byte sum and frame checks. Each step
// consumes one byte and may emit one frame status.
// ----------------------------------------------------------------------------
module cfd_frame_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [7:0]         i_byte,
    input  cfd_pkg::t_cfg      i_cfg,
    output logic               o_res_valid,
    output cfd_pkg::t_result   o_res
);

    localparam logic [1:0] PH_HUNT1   = 2'd0;
    localparam logic [1:0] PH_HUNT2   = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_pos, n_pos;
    // sum of frame bytes up to four behind the newest one
    logic [31:0] r_sum, n_sum;
    logic [7:0]  r_win [cfd_pkg::WinDepth];
    logic [7:0]  n_win [cfd_pkg::WinDepth];

    logic        tail;
    logic        span_hit;
    logic        too_long;
    logic        too_short;
    logic        sum_bad;
    logic [8:0]  len9;
    logic [31:0] chk;

    always_comb begin
        tail      = (i_byte == cfd_pkg::CH_BANG) && (r_win[4] == cfd_pkg::CH_PCT)
                    && (r_pos >= 8'd5);
        span_hit  = (r_pos >= 8'd5) && ((r_pos - 8'd5) >= i_cfg.max_span);
        too_long  = (r_pos == 8'd255) || span_hit;
        len9      = {1'b0, r_pos} + 9'd1;
        too_short = len9 < {1'b0, i_cfg.min_len};
        chk       = {r_win[3], r_win[2], r_win[1], r_win[0]};
        sum_bad   = chk != r_sum;
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_win       = r_win;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.frame_length = (r_pos == 8'd255) ? 8'd255 : len9[7:0];

        if (i_adv) begin
            unique case (r_phase)
                PH_HUNT2: begin
                    if (i_byte == cfd_pkg::CH_AT) begin
                        n_phase = PH_COLLECT;
                        n_pos   = 8'd2;
                        n_sum   = '0;
                        for (int k = 0; k < cfd_pkg::WinDepth; k++) n_win[k] = '0;
                        n_win[0] = cfd_pkg::CH_AT;
                        n_win[1] = cfd_pkg::CH_AT;
                    end else begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_COLLECT: begin
                    n_win[0] = i_byte;
                    for (int k = 1; k < cfd_pkg::WinDepth; k++) n_win[k] = r_win[k-1];
                    n_sum = r_sum + 32'(r_win[3]);
                    if (!tail) begin
                        if ((r_pos == 8'd255) || span_hit) begin
                            n_phase = PH_HUNT1;
                            n_pos   = '0;
                        end else begin
                            n_pos = r_pos + 8'd1;
                        end
                    end else begin
                        o_res_valid = 1'b1;
                        n_phase     = PH_HUNT1;
                        n_pos       = '0;
                        if (too_long) begin
                            o_res.frame_status = cfd_pkg::ST_LONG;
                        end else if (too_short) begin
                            o_res.frame_status = cfd_pkg::ST_SHORT;
                        end else if (sum_bad) begin
                            o_res.frame_status = cfd_pkg::ST_CHECKSUM;
                        end else if (!cfd_pkg::is_digit(r_win[11])) begin
                            o_res.frame_status = cfd_pkg::ST_BAD_DOOR;
                        end else if (!cfd_pkg::is_digit(r_win[10])
                                     || !cfd_pkg::is_digit(r_win[9])
                                     || !cfd_pkg::is_digit(r_win[8])) begin
                            o_res.frame_status = cfd_pkg::ST_BAD_UP;
                        end else if (!cfd_pkg::is_digit(r_win[7])
                                     || !cfd_pkg::is_digit(r_win[6])
                                     || !cfd_pkg::is_digit(r_win[5])) begin
                            o_res.frame_status = cfd_pkg::ST_BAD_DOWN;
                        end else begin
                            o_res.frame_status    = cfd_pkg::ST_OK;
                            o_res.door_number     = r_win[11][3:0];
                            o_res.boarding_count  = cfd_pkg::dec3(r_win[10], r_win[9],
                                                                  r_win[8]);
                            o_res.alighting_count = cfd_pkg::dec3(r_win[7], r_win[6],
                                                                  r_win[5]);
                        end
                    end
                end
                default: begin
                    // first header byte hunt; the unused phase code hunts the same way
                    n_phase = (i_byte == cfd_pkg::CH_AT) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_win <= n_win;
    end

    a_res_from_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_adv && (r_phase == PH_COLLECT))
        else $error("frame status outside collect phase");

    a_restart_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == PH_HUNT1) && (r_pos == 8'd0))
        else $error("hunt not restarted after frame status");

    a_collect_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COLLECT) |-> (r_pos >= 8'd2))
        else $error("collect phase with position below header length");

    a_bad_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.frame_status != cfd_pkg::ST_OK)) |->
            (o_res.door_number == 4'd0) && (o_res.boarding_count == 10'd0)
            && (o_res.alighting_count == 10'd0))
        else $error("decoded fields set on a rejected frame");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_phase) && $stable(r_pos))
        else $error("frame state moved without a byte");

endmodule

@@ rtl/counter_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// counter_frame_deframer
// Byte-serial deframer for passenger-counter frames.
//
// i_byte carries one received byte per word. The block hunts for "@@", then
// collects bytes until a '%' is followed five bytes later by '!'. For each
// finished frame one word leaves on o_result: the status (span, length,
// big-endian additive checksum, then door and count digits), the decoded
// door and counts when the frame is good, and the frame length. Frames that
// run past the span or the position limit without a tail are dropped silently.
// i_cfg writes the registers: index 0 minimum frame length, index 1 maximum
// span; write them only while no byte is in flight.
// Throughput is one byte per cycle while o_result is not stalled; a byte
// passes an input register and the frame state update, and the status word
// of the closing '!' is registered in the result register. The frame state
// loop sets that rate.
// Reset returns to hunting and restores length 30 and span 200. When
// o_result stalls with a word waiting, at most one more byte is taken into
// the input register and i_byte.ready then drops until the word is taken.
// ----------------------------------------------------------------------------
module counter_frame_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfd_byte_if.sink      i_byte,
    cfd_cfg_if.sink       i_cfg,
    cfd_result_if.source  o_result
);

    cfd_pkg::t_cfg    cfg;
    cfd_pkg::t_result core_res;
    logic             core_res_valid;
    logic             adv;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    cfd_pkg::t_result r_out;

    cfd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign adv          = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_byte.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    cfd_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    // result register, only loaded when the slot is free or its word leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.frame_status    = r_out.frame_status;
    assign o_result.door_number     = r_out.door_number;
    assign o_result.boarding_count  = r_out.boarding_count;
    assign o_result.alighting_count = r_out.alighting_count;
    assign o_result.frame_length    = r_out.frame_length;

endmodule
